/* hdl/dts_pkg.sv */
// ----------------------------------------------------------------------------
// Deadline thread scheduler package
// Shared operation codes, status codes and the cell control struct.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int OP_W      = 3;
  localparam int DL_W      = 32;
  localparam int SEL_W     = 2;
  localparam int IDX_W     = 6;
  localparam int STATUS_W  = 2;
  localparam int SEM_CNT_W = 7;
  localparam int OFS_W     = 8;

  localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK     = 3'd1;
  localparam logic [OP_W-1:0] OP_DELAY    = 3'd2;
  localparam logic [OP_W-1:0] OP_TAKE     = 3'd3;
  localparam logic [OP_W-1:0] OP_GIVE     = 3'd4;
  localparam logic [OP_W-1:0] OP_YIELD    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IDLE_DELAY = 2'd2;

  // Per-cycle command applied to the entry passing the head of the ring.
  typedef struct packed {
    logic            wr_new;     // write a freshly registered thread
    logic            tick;       // decrement countdown
    logic            set_delay;  // load countdown with delay value
    logic [DL_W-1:0] data;       // deadline or delay value
  } cell_cmd_t;

endpackage

/* hdl/dts_cell.sv */
// ----------------------------------------------------------------------------
// Thread cell
// Holds one thread's deadline and countdown. While the ring rotates, the
// cell takes its neighbor's entry each cycle; otherwise it holds.
// ----------------------------------------------------------------------------
module dts_cell (
  input  logic        clk,
  input  logic        shift,      // rotate the chain one place
  input  logic [31:0] dl_in,
  input  logic [31:0] cd_in,
  output logic [31:0] dl_out,
  output logic [31:0] cd_out
);
  import dts_pkg::*;

  logic [DL_W-1:0] dl_r, dl_nxt;
  logic [DL_W-1:0] cd_r, cd_nxt;

  assign dl_out = dl_r;
  assign cd_out = cd_r;

  always_comb begin
    dl_nxt = dl_r;
    cd_nxt = cd_r;
    if (shift) begin
      dl_nxt = dl_in;
      cd_nxt = cd_in;
    end
  end

  always_ff @(posedge clk) begin
    dl_r <= dl_nxt;
    cd_r <= cd_nxt;
  end

endmodule

/* hdl/deadline_thread_scheduler.sv */
// ----------------------------------------------------------------------------
// Deadline thread scheduler
// Earliest-deadline-first selection over a rotating chain of thread cells.
// ----------------------------------------------------------------------------
// Usage: each input word on the in_ channel is one kernel operation
// (register, tick, delay, semaphore take, give, yield). Each accepted word
// produces exactly one output word carrying the selected thread, a switch
// request flag, the ready mask and a status code.
// Thread entries sit in a ring of MAX_THREADS cells that rotates one place
// per cycle while a word is scanned. An operation is launched from S_IDLE,
// takes one full revolution of the ring in S_SCAN, and posts its result in
// S_DONE, which waits for the output register to be free. The revolution is
// needed because ticks, wakes, writes and the minimum-deadline search all
// happen at the head cell as each entry passes by.
// The result waits in an output register; a new word is accepted while it
// waits, but its result is posted only after the old one is taken.
// Configuration writes on the cfg_ channel are always accepted and set the
// initial semaphore token counts; write them only while the block is idle.
// Reset (rst_n low, synchronous) empties the table, clears ready and
// blocked masks and semaphore offsets, and selects the idle thread 0.
// ----------------------------------------------------------------------------
module deadline_thread_scheduler #(
  parameter int MAX_THREADS    = 32,
  parameter int NUM_SEMAPHORES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] op, [34:3] new_deadline, [66:35] delay_ticks, [68:67] sem_select
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [5:0] next_thread, [6] switch_request, [38:7] ready_bits, [40:39] status
  output logic [47:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import dts_pkg::*;

  localparam int PW = $clog2(MAX_THREADS);
  localparam int SW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Control state
  logic [IDX_W-1:0]  count_r;      // registered user threads
  logic [IDX_W-1:0]  run_r;
  logic [31:0]       ready_r;
  logic [OFS_W-1:0]  ofs_r [NUM_SEMAPHORES];
  logic [31:0]       blk_r [NUM_SEMAPHORES];
  logic [SEM_CNT_W-1:0] init_r [4];

  // Operation latched for the scan
  logic [OP_W-1:0]   op_r;
  logic [DL_W-1:0]   arg_r;        // deadline or delay value
  logic              do_pass_r;
  logic              wr_new_r;
  logic              set_delay_r;
  logic [IDX_W-1:0]  target_r;     // thread the head write applies to
  logic [PW:0]       pos_r;        // scan position 0..MAX_THREADS
  logic              found_r;
  logic [DL_W-1:0]   best_r;
  logic [IDX_W-1:0]  pick_r;
  logic [IDX_W-1:0]  before_r;
  logic [STATUS_W-1:0] status_r;

  // Output holding register
  logic              ov_r;
  logic [47:0]       od_r;

  // Decoded input fields
  logic [OP_W-1:0]   in_op;
  logic [DL_W-1:0]   in_dl, in_delay;
  logic [SEL_W-1:0]  in_sel;
  assign in_op    = in_tdata[2:0];
  assign in_dl    = in_tdata[34:3];
  assign in_delay = in_tdata[66:35];
  assign in_sel   = in_tdata[68:67];

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // Decode of the offered word: what the scan must do and how the
  // semaphore offsets move.
  logic [STATUS_W-1:0] dec_status;
  logic                dec_pass, dec_wr_new, dec_set_delay;
  logic [IDX_W-1:0]    dec_target;
  logic [DL_W-1:0]     dec_arg;
  logic [SW-1:0]       sem_idx;
  logic                sem_ok;
  logic [OFS_W-1:0]    take_ofs, give_ofs;
  logic [31:0]         blk_sel, blk_low;
  logic                take_blocks, give_wakes;

  assign sem_idx = SW'(in_sel);
  assign sem_ok  = ({2'b00, in_sel} < 4'(NUM_SEMAPHORES));

  always_comb begin
    dec_status    = ST_OK;
    dec_pass      = 1'b0;
    dec_wr_new    = 1'b0;
    dec_set_delay = 1'b0;
    dec_target    = '0;
    dec_arg       = in_dl;
    // The offset saturates at +127 on take and at -128 on give.
    take_ofs = ofs_r[sem_idx];
    give_ofs = ofs_r[sem_idx];
    if (ofs_r[sem_idx] != 8'h7F) take_ofs = ofs_r[sem_idx] + 8'd1;
    if (ofs_r[sem_idx] != 8'h80) give_ofs = ofs_r[sem_idx] - 8'd1;
    // Token is initial count minus offset.
    take_blocks = ($signed({2'b0, init_r[in_sel]}) < $signed({take_ofs[7], take_ofs}));
    give_wakes  = ($signed({2'b0, init_r[in_sel]}) <= $signed({give_ofs[7], give_ofs}));
    blk_sel = blk_r[sem_idx];
    blk_low = blk_sel & (~blk_sel + 32'd1);
    unique case (in_op)
      OP_REGISTER: begin
        if (count_r >= IDX_W'(MAX_THREADS)) begin
          dec_status = ST_TABLE_FULL;
        end else begin
          dec_wr_new = 1'b1;
          dec_target = count_r + IDX_W'(1);
        end
      end
      OP_DELAY: begin
        if (run_r == '0) begin
          dec_status = ST_IDLE_DELAY;
        end else begin
          dec_set_delay = 1'b1;
          dec_target    = run_r;
          dec_arg       = in_delay;
          dec_pass      = 1'b1;
        end
      end
      OP_TAKE:  if (sem_ok && run_r != '0 && take_blocks) dec_pass = 1'b1;
      OP_GIVE:  if (sem_ok && give_wakes) dec_pass = 1'b1;
      OP_YIELD: dec_pass = 1'b1;
      default: ;
    endcase
  end

  // Ring of cells; the head is cell 0, which holds thread pos_r+1.
  logic [31:0] dl_q [MAX_THREADS];
  logic [31:0] cd_q [MAX_THREADS];
  cell_cmd_t cmd;
  logic shift, head_hit;

  assign shift    = (state_r == S_SCAN);
  assign head_hit = shift && (target_r == IDX_W'(pos_r) + IDX_W'(1));
  always_comb begin
    cmd.wr_new    = head_hit && wr_new_r;
    cmd.set_delay = head_hit && set_delay_r;
    cmd.tick      = shift && (op_r == OP_TICK);
    cmd.data      = arg_r;
  end

  // Apply the head update first, then rotate: the head cell's new contents
  // move to the tail, so the ring sees a post-update copy.
  logic [31:0] head_dl, head_cd;
  always_comb begin
    head_dl = dl_q[0];
    head_cd = cd_q[0];
    if (cmd.wr_new) begin
      head_dl = arg_r;
      head_cd = '0;
    end else if (cmd.set_delay) begin
      head_cd = arg_r;
    end else if (cmd.tick && cd_q[0] != '0) begin
      head_cd = cd_q[0] - 32'd1;
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_THREADS; g++) begin : g_cell
      dts_cell u_cell (
        .clk    (clk),
        .shift  (shift),
        .dl_in  ((g == MAX_THREADS-1) ? head_dl : dl_q[(g+1) % MAX_THREADS]),
        .cd_in  ((g == MAX_THREADS-1) ? head_cd : cd_q[(g+1) % MAX_THREADS]),
        .dl_out (dl_q[g]),
        .cd_out (cd_q[g])
      );
    end
  endgenerate

  // Current thread under the head and its status.
  logic [IDX_W-1:0] cur;
  logic             cur_valid, cur_ready;
  logic             cur_wake;
  assign cur       = IDX_W'(pos_r) + IDX_W'(1);
  assign cur_valid = (cur <= count_r);
  assign cur_wake  = cur_valid && (op_r == OP_TICK) && (cd_q[0] == 32'd1);

  logic [31:0] ready_scan;
  always_comb begin
    ready_scan = ready_r;
    if (cur_wake) ready_scan[pos_r[PW-1:0]] = 1'b1;
  end
  assign cur_ready = cur_valid && ready_scan[pos_r[PW-1:0]];

  integer k;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      run_r   <= '0;
      ready_r <= '0;
      ov_r    <= 1'b0;
      for (k = 0; k < NUM_SEMAPHORES; k++) begin
        ofs_r[k] <= '0;
        blk_r[k] <= '0;
      end
      for (k = 0; k < 4; k++) init_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) init_r[cfg_index] <= cfg_data;
      // A word taken while a new result is posted is replaced in S_DONE.
      if (ov_r && out_tready && state_r != S_DONE) ov_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r        <= in_op;
            before_r    <= run_r;
            status_r    <= dec_status;
            do_pass_r   <= dec_pass;
            wr_new_r    <= dec_wr_new;
            set_delay_r <= dec_set_delay;
            target_r    <= dec_target;
            arg_r       <= dec_arg;
            pos_r       <= '0;
            found_r     <= 1'b0;
            best_r      <= '1;
            pick_r      <= '0;
            unique case (in_op)
              OP_REGISTER: begin
                if (dec_wr_new) begin
                  ready_r[count_r[4:0]] <= 1'b1;
                  count_r <= count_r + IDX_W'(1);
                end
              end
              OP_DELAY: begin
                if (dec_set_delay) ready_r[run_r[4:0] - 5'd1] <= 1'b0;
              end
              OP_TAKE: begin
                if (sem_ok && run_r != '0) begin
                  ofs_r[sem_idx] <= take_ofs;
                  if (take_blocks) begin
                    blk_r[sem_idx][run_r[4:0] - 5'd1] <= 1'b1;
                    ready_r[run_r[4:0] - 5'd1] <= 1'b0;
                  end
                end
              end
              OP_GIVE: begin
                if (sem_ok) begin
                  ofs_r[sem_idx] <= give_ofs;
                  if (give_wakes) begin
                    blk_r[sem_idx] <= blk_sel & ~blk_low;
                    ready_r        <= ready_r | blk_low;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          pos_r <= pos_r + 1'b1;
          if (cur_wake) ready_r[pos_r[PW-1:0]] <= 1'b1;
          if (cur_ready) begin
            logic [31:0] d;
            d = cmd.wr_new ? arg_r : dl_q[0];
            if (!found_r || d < best_r) begin
              found_r <= 1'b1;
              best_r  <= d;
              pick_r  <= cur;
            end
          end
        end
        S_DONE: begin
          if (!ov_r || out_tready) begin
            logic [IDX_W-1:0] nr;
            nr = do_pass_r ? pick_r : run_r;
            run_r <= nr;
            ov_r  <= 1'b1;
            od_r  <= {7'd0, status_r, ready_r, (nr != before_r), nr};
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_SCAN;
      S_SCAN: if (pos_r == (PW+1)'(MAX_THREADS - 1)) state_nxt = S_DONE;
      S_DONE: if (!ov_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Deadline thread scheduler testbench
// Drives kernel operations into the scheduler with random idling on both
// sides, predicts each result word from a behavioral scheduler model kept in
// the testbench, and compares every output word field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import dts_pkg::*;

  localparam int NTHR      = 32;
  localparam int NSEM      = 4;
  localparam int WDOG_MAX  = 20000;
  localparam int HOLD_LEN  = 400;

  typedef struct packed {
    logic [1:0]  sem;
    logic [31:0] delay;
    logic [31:0] deadline;
    logic [2:0]  op;
  } kop_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] ready;
    logic        sw;
    logic [5:0]  next;
  } sched_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_data;

  deadline_thread_scheduler uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Scheduler state mirrored by the predictor.
  logic [6:0]  sem_init [NSEM];
  int unsigned thr_count;
  int unsigned run_thr;
  logic [31:0] rdy_mask;
  logic [31:0] dl_tab [NTHR];
  logic [31:0] cd_tab [NTHR];
  int          sem_ofs [NSEM];
  logic [31:0] blk_mask [NSEM];

  kop_t       pending_ops[$];
  sched_res_t expected_res[$];
  int         errors;
  bit         quiet;      // no idling in the final part of the run
  bit         hold_req;   // ask the receiver for a long hold-off
  bit         gen_done;

  // Selection pass: earliest deadline among ready threads, lowest index wins ties.
  function automatic int unsigned pick_edf();
    int unsigned pick;
    logic [31:0] best;
    bit found;
    pick = 0;
    best = '1;
    found = 0;
    for (int unsigned i = 1; i < thr_count && i <= NTHR; i++) begin
      if (rdy_mask[i-1] && (!found || dl_tab[i-1] < best)) begin
        found = 1;
        best = dl_tab[i-1];
        pick = i;
      end
    end
    return pick;
  endfunction

  function automatic sched_res_t schedule_op(kop_t k);
    sched_res_t r;
    int unsigned prev;
    prev = run_thr;
    r.status = ST_OK;
    case (k.op)
      OP_REGISTER: begin
        if (thr_count > NTHR) begin
          r.status = ST_TABLE_FULL;
        end else begin
          dl_tab[thr_count-1] = k.deadline;
          cd_tab[thr_count-1] = '0;
          rdy_mask[thr_count-1] = 1'b1;
          thr_count++;
        end
      end
      OP_TICK: begin
        for (int unsigned i = 1; i < thr_count && i <= NTHR; i++) begin
          if (cd_tab[i-1] != 0) begin
            cd_tab[i-1]--;
            if (cd_tab[i-1] == 0) rdy_mask[i-1] = 1'b1;
          end
        end
      end
      OP_DELAY: begin
        if (run_thr == 0) begin
          r.status = ST_IDLE_DELAY;
        end else begin
          cd_tab[run_thr-1] = k.delay;
          rdy_mask[run_thr-1] = 1'b0;
          run_thr = pick_edf();
        end
      end
      OP_TAKE: begin
        if (k.sem < NSEM && run_thr != 0) begin
          if (sem_ofs[k.sem] < 127) sem_ofs[k.sem]++;
          if (int'(sem_init[k.sem]) - sem_ofs[k.sem] < 0) begin
            blk_mask[k.sem][run_thr-1] = 1'b1;
            rdy_mask[run_thr-1] = 1'b0;
            run_thr = pick_edf();
          end
        end
      end
      OP_GIVE: begin
        if (k.sem < NSEM) begin
          if (sem_ofs[k.sem] > -128) sem_ofs[k.sem]--;
          if (int'(sem_init[k.sem]) - sem_ofs[k.sem] <= 0) begin
            // Wake the lowest-index blocked thread, if any.
            for (int unsigned i = 1; i < thr_count && i <= NTHR; i++) begin
              if (blk_mask[k.sem][i-1]) begin
                blk_mask[k.sem][i-1] = 1'b0;
                rdy_mask[i-1] = 1'b1;
                break;
              end
            end
            run_thr = pick_edf();
          end
        end
      end
      OP_YIELD: run_thr = pick_edf();
      default: ;
    endcase
    r.next = run_thr[5:0];
    r.sw = (run_thr != prev);
    r.ready = rdy_mask;
    return r;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Input driver: offers the oldest pending word, with random gaps. The
  // accepted word leaves the queue first, so the next offer is its head.
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_res.push_back(schedule_op(pending_ops.pop_front()));
      end
      if (in_tvalid && !in_tready) begin
        // Keep offering the same word.
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap <= $urandom_range(0, 4);
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata <= {3'b0, pending_ops[0]};
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output monitor: checks each accepted word against the oldest expectation.
  int out_gap;
  int hold_cnt;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
      hold_cnt <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        sched_res_t got, exp_r;
        got = out_tdata[40:0];
        if (expected_res.size() == 0) begin
          $error("unexpected output word %h", out_tdata);
          errors++;
        end else begin
          exp_r = expected_res.pop_front();
          if (got.next !== exp_r.next) begin
            $error("next_thread: expected %0d, actual %0d", exp_r.next, got.next);
            errors++;
          end
          if (got.sw !== exp_r.sw) begin
            $error("switch_request: expected %0d, actual %0d", exp_r.sw, got.sw);
            errors++;
          end
          if (got.ready !== exp_r.ready) begin
            $error("ready_bits: expected %h, actual %h", exp_r.ready, got.ready);
            errors++;
          end
          if (got.status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, got.status);
            errors++;
          end
        end
      end
      if (hold_req && hold_cnt == 0) begin
        hold_cnt <= HOLD_LEN;
        out_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_gap <= $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready) || gen_done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic kop_t mk_op(logic [2:0] op, logic [31:0] dl, logic [31:0] dy,
                                 logic [1:0] sm);
    kop_t k;
    k.op = op;
    k.deadline = dl;
    k.delay = dy;
    k.sem = sm;
    return k;
  endfunction

  // Random word biased toward meaningful kernel traffic; small delays so
  // threads wake up again, and the odd unknown op.
  function automatic kop_t rand_op();
    int unsigned sel;
    logic [31:0] dl, dy;
    sel = $urandom_range(0, 99);
    dl = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40);
    dy = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 6);
    if (sel < 8)       return mk_op(OP_REGISTER, dl, $urandom, 2'($urandom));
    else if (sel < 35) return mk_op(OP_TICK, $urandom, $urandom, 2'($urandom));
    else if (sel < 50) return mk_op(OP_DELAY, $urandom, dy, 2'($urandom));
    else if (sel < 68) return mk_op(OP_TAKE, $urandom, $urandom, 2'($urandom));
    else if (sel < 86) return mk_op(OP_GIVE, $urandom, $urandom, 2'($urandom));
    else if (sel < 97) return mk_op(OP_YIELD, $urandom, $urandom, 2'($urandom));
    else               return mk_op(3'($urandom_range(6, 7)), $urandom, $urandom,
                                    2'($urandom));
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sem_init[idx] = val;
    cfg_valid <= 1'b0;
  endtask

  // Wait until every expected word has arrived, then let the block settle.
  task automatic drain();
    while (pending_ops.size() != 0 || expected_res.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Soft reset of the model's table between phases is impossible, so each
  // phase continues from the block's state; only the semaphore counts change.
  task automatic run_phase(input int n, input logic [6:0] c0, input logic [6:0] c1,
                           input logic [6:0] c2, input logic [6:0] c3);
    write_reg(2'd0, c0);
    write_reg(2'd1, c1);
    write_reg(2'd2, c2);
    write_reg(2'd3, c3);
    for (int i = 0; i < n; i++) pending_ops.push_back(rand_op());
    drain();
  endtask

  initial begin
    errors = 0;
    quiet = 0;
    hold_req = 0;
    gen_done = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    thr_count = 1;
    run_thr = 0;
    rdy_mask = '0;
    for (int i = 0; i < NTHR; i++) begin
      dl_tab[i] = '0;
      cd_tab[i] = '0;
    end
    for (int i = 0; i < NSEM; i++) begin
      sem_init[i] = '0;
      sem_ofs[i] = 0;
      blk_mask[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with all counts at zero: idle-thread corner cases, an
    // all-ones and a zero deadline, a give with nobody blocked, a take that
    // blocks, a delay that never wakes, a tie on deadlines and unknown ops.
    pending_ops.push_back(mk_op(OP_DELAY, '0, 32'd3, 2'd0));        // idle delay
    pending_ops.push_back(mk_op(OP_TAKE, '0, '0, 2'd1));            // idle take
    pending_ops.push_back(mk_op(OP_YIELD, '0, '0, 2'd0));
    pending_ops.push_back(mk_op(OP_REGISTER, 32'hFFFF_FFFF, '0, 2'd0));
    pending_ops.push_back(mk_op(OP_YIELD, '0, '0, 2'd0));           // max deadline picked
    pending_ops.push_back(mk_op(OP_REGISTER, 32'd0, 32'hFFFF_FFFF, 2'd3));
    pending_ops.push_back(mk_op(OP_REGISTER, 32'd0, '0, 2'd0));     // tie
    pending_ops.push_back(mk_op(OP_GIVE, '0, '0, 2'd2));            // nobody blocked
    pending_ops.push_back(mk_op(OP_TAKE, '0, '0, 2'd2));
    pending_ops.push_back(mk_op(OP_TAKE, '0, '0, 2'd2));            // blocks
    pending_ops.push_back(mk_op(OP_DELAY, '0, 32'd2, 2'd0));
    pending_ops.push_back(mk_op(OP_TICK, '0, '0, 2'd0));
    pending_ops.push_back(mk_op(OP_TICK, '0, '0, 2'd0));            // wakes
    pending_ops.push_back(mk_op(OP_GIVE, '0, '0, 2'd2));            // unblocks
    pending_ops.push_back(mk_op(OP_DELAY, '0, 32'd0, 2'd0));        // never wakes
    pending_ops.push_back(mk_op(3'd6, '1, '1, 2'd3));
    pending_ops.push_back(mk_op(3'd7, '0, '0, 2'd0));
    pending_ops.push_back(mk_op(OP_TAKE, '0, '0, 2'd3));
    pending_ops.push_back(mk_op(OP_YIELD, '1, '1, 2'd3));
    drain();

    // Long receiver hold-off while the sender keeps offering words.
    for (int i = 0; i < 30; i++) pending_ops.push_back(mk_op(OP_TICK, '0, '0, 2'd0));
    hold_req = 1;
    wait (hold_cnt != 0);
    hold_req = 0;
    drain();

    // Fill the table to its end and beyond.
    for (int i = 0; i < 32; i++)
      pending_ops.push_back(mk_op(OP_REGISTER, $urandom_range(0, 60), '0, 2'd0));
    pending_ops.push_back(mk_op(OP_YIELD, '0, '0, 2'd0));
    drain();

    run_phase(300, 7'd0, 7'd0, 7'd0, 7'd0);
    run_phase(300, 7'd127, 7'd127, 7'd127, 7'd127);
    // Drive the offset of semaphore 1 toward its negative limit with many gives.
    for (int i = 0; i < 140; i++) pending_ops.push_back(mk_op(OP_GIVE, '0, '0, 2'd1));
    drain();
    run_phase(300, 7'd1, 7'd2, 7'd64, 7'd0);
    quiet = 1;
    run_phase(300, 7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));

    gen_done = 1;
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/dts_pkg.sv
hdl/dts_cell.sv
hdl/deadline_thread_scheduler.sv
sim/tb_top.sv
